FILE: hw/rtl/bfct_pkg.sv
package bfct_pkg;

	// Defaults for the top-level parameters
	localparam int PLANE_COUNT_DEF = 4;
	localparam int COORD_BITS_DEF  = 32;

	// Fixed formats of the plane registers
	localparam int NORMAL_BITS     = 16;	// one signed Q2.14 component
	localparam int NORMAL_REG_BITS = 3 * NORMAL_BITS;
	localparam int OFFSET_BITS     = 32;	// signed Q16.16
	localparam int FRAC_ALIGN      = 14;	// Q.16 to Q.30 alignment shift
	localparam int AXIS_COUNT      = 3;

	// Register file layout: 64-bit registers on an 8-byte stride
	localparam int APB_DATA_BITS   = 64;
	localparam int REG_ADDR_SHIFT  = 3;

	// Component j of a packed normal register
	function automatic logic signed [NORMAL_BITS-1:0] normal_comp(
		input logic [NORMAL_REG_BITS-1:0] nreg,
		input int                         axis
	);
		return signed'(nreg[NORMAL_BITS*axis +: NORMAL_BITS]);
	endfunction

endpackage

FILE: hw/rtl/box_frustum_clip_test.sv
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+-------------------------------------------
// object   | obj_valid / obj_ready       | is_rotated, center_*, bound_radius, box_*
// result   | res_valid / res_ready       | fully_clipped, straddle_mask
// config   | psel/penable/pwrite, pready | paddr, pwdata, prdata (8-byte stride)
//
// One object enters per cycle while obj_ready is high; its result is registered through the stages
// operand select, multiply, partial sum, final sum and sign test, and result register.
// The multiply stage (six 32x16 products per plane) sets the stage depth.
// arst_n clears all valid bits and the plane registers.
// Each stage advances when its successor is empty or advancing, so bubbles close up
// and a stalled result does not block intake until the whole pipe is full.
module box_frustum_clip_test #(
	parameter int PLANE_COUNT = bfct_pkg::PLANE_COUNT_DEF,
	parameter int COORD_BITS  = bfct_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [$clog2(16*PLANE_COUNT)-1:0]      paddr,
	input  logic [bfct_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [bfct_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                   pready,
	// object channel
	input  logic                                   obj_valid,
	output logic                                   obj_ready,
	input  logic                                   is_rotated,
	input  logic signed [COORD_BITS-1:0]           center_x,
	input  logic signed [COORD_BITS-1:0]           center_y,
	input  logic signed [COORD_BITS-1:0]           center_z,
	input  logic [COORD_BITS-2:0]                  bound_radius,
	input  logic signed [COORD_BITS-1:0]           box_min_x,
	input  logic signed [COORD_BITS-1:0]           box_min_y,
	input  logic signed [COORD_BITS-1:0]           box_min_z,
	input  logic signed [COORD_BITS-1:0]           box_max_x,
	input  logic signed [COORD_BITS-1:0]           box_max_y,
	input  logic signed [COORD_BITS-1:0]           box_max_z,
	// result channel
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output logic                                   fully_clipped,
	output logic [PLANE_COUNT-1:0]                 straddle_mask
);
	import bfct_pkg::*;

	localparam int CW      = COORD_BITS;
	localparam int NW      = NORMAL_BITS;
	localparam int PROD_W  = CW + NW;
	localparam int WIDE_W  = (CW > OFFSET_BITS) ? CW : OFFSET_BITS;
	localparam int DIFF_W  = WIDE_W + 2;
	localparam int BIAS_W  = DIFF_W + FRAC_ALIGN;
	localparam int SUM_W   = ((PROD_W > BIAS_W) ? PROD_W : BIAS_W) + 3;
	localparam int PADDR_W = $clog2(16*PLANE_COUNT);
	localparam int IDX_W   = PADDR_W - REG_ADDR_SHIFT;

	// ---------------------------------------------------------------
	// Plane registers
	// ---------------------------------------------------------------
	logic [NORMAL_REG_BITS-1:0] normal_q [PLANE_COUNT];
	logic signed [OFFSET_BITS-1:0] offset_q [PLANE_COUNT];
	logic [IDX_W-1:0] cfg_idx;
	logic cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[PADDR_W-1:REG_ADDR_SHIFT];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				normal_q[p] <= '0;
				offset_q[p] <= '0;
			end
		end else if (cfg_wr) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				if (int'(cfg_idx) == p)
					normal_q[p] <= pwdata[NORMAL_REG_BITS-1:0];
				if (int'(cfg_idx) == PLANE_COUNT + p)
					offset_q[p] <= signed'(pwdata[OFFSET_BITS-1:0]);
			end
		end
	end

	// register readback
	always_comb begin
		prdata = '0;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			if (int'(cfg_idx) == p)
				prdata = APB_DATA_BITS'(normal_q[p]);
			if (int'(cfg_idx) == PLANE_COUNT + p)
				prdata = APB_DATA_BITS'(unsigned'(offset_q[p]));
		end
	end

	// ---------------------------------------------------------------
	// Stage handshake: a stage loads when it is empty or its successor loads
	// ---------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, res_valid_q;
	logic en_s1, en_s2, en_s3, en_s4, en_out;

	assign en_out    = !res_valid_q || res_ready;
	assign en_s4     = !v_s4 || en_out;
	assign en_s3     = !v_s3 || en_s4;
	assign en_s2     = !v_s2 || en_s3;
	assign en_s1     = !v_s1 || en_s2;
	assign obj_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1        <= obj_valid;
			if (en_s2)  v_s2        <= v_s1;
			if (en_s3)  v_s3        <= v_s2;
			if (en_s4)  v_s4        <= v_s3;
			if (en_out) res_valid_q <= v_s4;
		end
	end

	// ---------------------------------------------------------------
	// Operand select: test point and aligned bias per plane
	// Point a / bias a feed the full-clip test, point b / bias b the straddle test.
	// ---------------------------------------------------------------
	logic signed [CW-1:0] ctr_in  [AXIS_COUNT];
	logic signed [CW-1:0] bmin_in [AXIS_COUNT];
	logic signed [CW-1:0] bmax_in [AXIS_COUNT];
	logic signed [NW-1:0] nrm_c   [PLANE_COUNT][AXIS_COUNT];
	logic signed [CW-1:0] pa_c    [PLANE_COUNT][AXIS_COUNT];
	logic signed [CW-1:0] pb_c    [PLANE_COUNT][AXIS_COUNT];
	logic signed [DIFF_W-1:0] da_c [PLANE_COUNT];
	logic signed [DIFF_W-1:0] db_c [PLANE_COUNT];

	assign ctr_in[0]  = center_x;
	assign ctr_in[1]  = center_y;
	assign ctr_in[2]  = center_z;
	assign bmin_in[0] = box_min_x;
	assign bmin_in[1] = box_min_y;
	assign bmin_in[2] = box_min_z;
	assign bmax_in[0] = box_max_x;
	assign bmax_in[1] = box_max_y;
	assign bmax_in[2] = box_max_z;

	always_comb begin
		logic signed [DIFF_W-1:0] radius_w;
		logic signed [DIFF_W-1:0] dist_w;
		radius_w = signed'(DIFF_W'(bound_radius));
		for (int p = 0; p < PLANE_COUNT; p++) begin
			dist_w = DIFF_W'(offset_q[p]);
			for (int j = 0; j < AXIS_COUNT; j++) begin
				nrm_c[p][j] = normal_comp(normal_q[p], j);
				if (is_rotated) begin
					pa_c[p][j] = ctr_in[j];
					pb_c[p][j] = ctr_in[j];
				end else if (nrm_c[p][j][NW-1]) begin
					// negative component: minimum lies farthest along the normal
					pa_c[p][j] = bmin_in[j];
					pb_c[p][j] = bmax_in[j];
				end else begin
					pa_c[p][j] = bmax_in[j];
					pb_c[p][j] = bmin_in[j];
				end
			end
			if (is_rotated) begin
				da_c[p] = radius_w - dist_w;
				db_c[p] = -dist_w - radius_w;
			end else begin
				da_c[p] = -dist_w;
				db_c[p] = -dist_w;
			end
		end
	end

	// ---------------------------------------------------------------
	// Pipeline payload
	// ---------------------------------------------------------------
	logic signed [CW-1:0]     pa_s1 [PLANE_COUNT][AXIS_COUNT];
	logic signed [CW-1:0]     pb_s1 [PLANE_COUNT][AXIS_COUNT];
	logic signed [DIFF_W-1:0] da_s1 [PLANE_COUNT];
	logic signed [DIFF_W-1:0] db_s1 [PLANE_COUNT];

	logic signed [PROD_W-1:0] ma_s2 [PLANE_COUNT][AXIS_COUNT];
	logic signed [PROD_W-1:0] mb_s2 [PLANE_COUNT][AXIS_COUNT];
	logic signed [DIFF_W-1:0] da_s2 [PLANE_COUNT];
	logic signed [DIFF_W-1:0] db_s2 [PLANE_COUNT];

	logic signed [SUM_W-1:0]  sa0_s3 [PLANE_COUNT];
	logic signed [SUM_W-1:0]  sa1_s3 [PLANE_COUNT];
	logic signed [SUM_W-1:0]  sb0_s3 [PLANE_COUNT];
	logic signed [SUM_W-1:0]  sb1_s3 [PLANE_COUNT];

	logic signed [SUM_W-1:0]  tot_a [PLANE_COUNT];
	logic signed [SUM_W-1:0]  tot_b [PLANE_COUNT];
	logic [PLANE_COUNT-1:0]   clip_s4, strad_s4;
	logic                     fully_clipped_q;
	logic [PLANE_COUNT-1:0]   straddle_q;

	// stage 1: capture operands
	always_ff @(posedge clk) begin
		if (en_s1) begin
			pa_s1 <= pa_c;
			pb_s1 <= pb_c;
			da_s1 <= da_c;
			db_s1 <= db_c;
		end
	end

	// stage 2: exact Q18.30 products
	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				for (int j = 0; j < AXIS_COUNT; j++) begin
					ma_s2[p][j] <= pa_s1[p][j] * nrm_c[p][j];
					mb_s2[p][j] <= pb_s1[p][j] * nrm_c[p][j];
				end
			end
			da_s2 <= da_s1;
			db_s2 <= db_s1;
		end
	end

	// stage 3: pairwise sums, bias aligned to Q.30
	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				sa0_s3[p] <= SUM_W'(ma_s2[p][0]) + SUM_W'(ma_s2[p][1]);
				sb0_s3[p] <= SUM_W'(mb_s2[p][0]) + SUM_W'(mb_s2[p][1]);
				sa1_s3[p] <= SUM_W'(ma_s2[p][2])
					+ SUM_W'(signed'({da_s2[p], {FRAC_ALIGN{1'b0}}}));
				sb1_s3[p] <= SUM_W'(mb_s2[p][2])
					+ SUM_W'(signed'({db_s2[p], {FRAC_ALIGN{1'b0}}}));
			end
		end
	end

	// stage 4: final sum and "at or below zero" test
	always_comb begin
		for (int p = 0; p < PLANE_COUNT; p++) begin
			tot_a[p] = sa0_s3[p] + sa1_s3[p];
			tot_b[p] = sb0_s3[p] + sb1_s3[p];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int p = 0; p < PLANE_COUNT; p++) begin
				clip_s4[p]  <= tot_a[p][SUM_W-1] || (tot_a[p] == '0);
				strad_s4[p] <= tot_b[p][SUM_W-1] || (tot_b[p] == '0);
			end
		end
	end

	// result register: any clipping plane wins and clears the mask
	always_ff @(posedge clk) begin
		if (en_out) begin
			fully_clipped_q <= |clip_s4;
			straddle_q      <= (|clip_s4) ? '0 : strad_s4;
		end
	end

	assign res_valid     = res_valid_q;
	assign fully_clipped = fully_clipped_q;
	assign straddle_mask = straddle_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_clip_clears_mask: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && fully_clipped |-> straddle_mask == '0)
		else $error("clipped result carries straddle bits");

	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		obj_valid && obj_ready |=> v_s1)
		else $error("accepted object did not enter stage 1");

	a_s4_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && en_out |=> res_valid)
		else $error("stage 4 item lost on the way to the result register");

	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && v_s2 && v_s3 && v_s4 && res_valid_q) |-> obj_ready)
		else $error("intake stalled while the pipe has room");

endmodule
